@@ rtl/ps2mq_pkg.sv @@
// Shared types and constants for the PS/2 mouse packet queue.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
`default_nettype none

package ps2mq_pkg;

  // Bit of the first packet byte that is always one; used to find packet starts.
  localparam int unsigned SyncBit = 3;
  localparam int unsigned ButtonBits = 3;
  localparam int unsigned UsedBits = 6;

  typedef enum logic [1:0] {
    CMD_STATUS,
    CMD_READ,
    CMD_PACKET
  } cmd_kind_e;

  // One classified item handed from the front end to the back end.
  typedef struct packed {
    cmd_kind_e       kind;
    logic            wide;   // four-byte packet
    logic [3:0][7:0] bytes;  // buttons, dx, dy, fourth byte
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [UsedBits-1:0] bytes_used;
    logic                packet_dropped;
    logic                packet_queued;
    logic                has_data;
    logic [7:0]          read_byte;
    logic                read_valid;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/ps2_mouse_packet_queue.sv @@
// PS/2 mouse packet queue: deframes mouse bytes into packets and buffers them.
// Top level; depends on ps2mq_pkg, ps2mq_front, ps2mq_cmdq and ps2mq_back.
//
// Input items arrive on the s_axis channel. tuser bit 0 is func (0 = a received
// byte, 1 = read one queued byte) and tuser bit 1 is from_aux; tdata carries the
// received byte. Every input item gives exactly one result item on m_axis.
// The cfg channel writes wheel_mode (1 = four-byte packets); it is always ready
// and the user must write it only while no item is in flight; not enforced.
// The front end classifies an item in the cycle it is accepted and hands it to
// a two-entry command queue, so input is taken back to back while the back end
// works. The back end answers a status item or a read of an empty queue
// directly, and a read through a memory fetch (single-port memory with
// registered read); a stored packet takes one memory write per byte plus
// issue and result states, and its result is loaded in the final state.
// Results sit in an output register; when the receiver stalls, the back end
// waits and the command queue fills, after which s_axis_tready drops.
// Reset clears the packet phase, the queue pointers and wheel_mode; queue
// contents are not cleared and no clearing pass is needed.
`default_nettype none

module ps2_mouse_packet_queue #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,     // wheel_mode
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  s_axis_tuser,   // [0] func, [1] from_aux
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] read_valid, [8:1] read_byte, [9] has_data, [10] packet_queued,
  // [11] packet_dropped, [17:12] bytes_used, [23:18] zero
  output logic [23:0]      m_axis_tdata
);

  logic               push_valid, push_ready;
  ps2mq_pkg::cmd_t    push_cmd;
  logic               cmd_valid, cmd_pop;
  ps2mq_pkg::cmd_t    cmd;
  ps2mq_pkg::result_t res;

  assign cfg_ready_o = 1'b1;

  ps2mq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .func_i      (s_axis_tuser[0]),
    .from_aux_i  (s_axis_tuser[1]),
    .rx_byte_i   (s_axis_tdata),
    .push_ready_i(push_ready),
    .in_ready_o  (s_axis_tready),
    .push_valid_o(push_valid),
    .push_cmd_o  (push_cmd)
  );

  ps2mq_cmdq u_cmdq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_cmd_i  (push_cmd),
    .push_ready_o(push_ready),
    .pop_i       (cmd_pop),
    .pop_valid_o (cmd_valid),
    .pop_cmd_o   (cmd)
  );

  ps2mq_back #(
    .QueueDepth(QUEUE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_valid_o(m_axis_tvalid),
    .res_o      (res),
    .res_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {6'd0, res};

endmodule

`default_nettype wire

@@ rtl/ps2mq_ram.sv @@
// Generic single-port RAM with registered read data.
// Read data holds its value while the port is not enabled for a read.
// No dependencies.
`default_nettype none

module ps2mq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/ps2mq_front.sv @@
// Front end: accepts items, tracks the packet phase and classifies each item.
// Depends on ps2mq_pkg.
`default_nettype none

module ps2mq_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_valid_i,
  input  wire logic            cfg_data_i,
  input  wire logic            in_valid_i,
  input  wire logic            func_i,
  input  wire logic            from_aux_i,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic            push_ready_i,
  output logic                 in_ready_o,
  output logic                 push_valid_o,
  output ps2mq_pkg::cmd_t      push_cmd_o
);

  logic       wheel_q;
  logic [1:0] phase_q, phase_d;
  logic [7:0] btn_q, btn_d;
  logic [7:0] dx_q, dx_d;
  logic [7:0] dy_q, dy_d;
  logic       accept;
  logic       complete;

  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i & push_ready_i;
  assign push_valid_o = accept;

  always_comb begin
    phase_d  = phase_q;
    btn_d    = btn_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    complete = 1'b0;
    if (!func_i && from_aux_i) begin
      unique case (phase_q)
        2'd0: begin
          if (rx_byte_i[ps2mq_pkg::SyncBit]) begin
            btn_d   = {5'd0, rx_byte_i[ps2mq_pkg::ButtonBits-1:0]};
            phase_d = 2'd1;
          end
        end
        2'd1: begin
          dx_d    = rx_byte_i;
          phase_d = 2'd2;
        end
        2'd2: begin
          dy_d = rx_byte_i;
          if (wheel_q) begin
            phase_d = 2'd3;
          end else begin
            phase_d  = 2'd0;
            complete = 1'b1;
          end
        end
        default: begin
          phase_d  = 2'd0;
          complete = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    push_cmd_o.wide  = wheel_q;
    push_cmd_o.bytes = {rx_byte_i, dy_d, dx_d, btn_d};
    if (func_i) begin
      push_cmd_o.kind = ps2mq_pkg::CMD_READ;
    end else if (complete) begin
      push_cmd_o.kind = ps2mq_pkg::CMD_PACKET;
    end else begin
      push_cmd_o.kind = ps2mq_pkg::CMD_STATUS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_q <= 1'b0;
      phase_q <= 2'd0;
      btn_q   <= 8'd0;
      dx_q    <= 8'd0;
      dy_q    <= 8'd0;
    end else begin
      if (cfg_valid_i) begin
        wheel_q <= cfg_data_i;
      end
      if (accept) begin
        phase_q <= phase_d;
        btn_q   <= btn_d;
        dx_q    <= dx_d;
        dy_q    <= dy_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ps2mq_cmdq.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on ps2mq_pkg.
`default_nettype none

module ps2mq_cmdq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ps2mq_pkg::cmd_t push_cmd_i,
  output logic                 push_ready_o,
  input  wire logic            pop_i,
  output logic                 pop_valid_o,
  output ps2mq_pkg::cmd_t      pop_cmd_o
);

  ps2mq_pkg::cmd_t entry_q [2];
  logic       wr_idx_q, rd_idx_q;
  logic [1:0] fill_q;
  logic       do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_cmd_o    = entry_q[rd_idx_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_idx_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= 1'b0;
      rd_idx_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_idx_q <= ~wr_idx_q;
      end
      if (do_pop) begin
        rd_idx_q <= ~rd_idx_q;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ps2mq_back.sv @@
// Back end: executes commands against the byte queue memory and registers results.
// Depends on ps2mq_pkg and ps2mq_ram.
`default_nettype none

module ps2mq_back #(
  parameter int unsigned QueueDepth = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  input  wire ps2mq_pkg::cmd_t cmd_i,
  output logic                 cmd_pop_o,
  output logic                 res_valid_o,
  output ps2mq_pkg::result_t   res_o,
  input  wire logic            res_ready_i
);

  localparam int unsigned AW = $clog2(QueueDepth);
  localparam logic [AW-1:0] LastSlot = AW'(QueueDepth - 1);
  localparam logic [AW:0] DepthC = (AW + 1)'(QueueDepth);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WR    = 2'd1;
  localparam logic [1:0] ST_FIN   = 2'd2;
  localparam logic [1:0] ST_RWAIT = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]   count_q, count_d;
  logic [1:0]      idx_q, idx_d;
  ps2mq_pkg::cmd_t pkt_q, pkt_d;
  logic            out_valid_q, out_valid_d;
  ps2mq_pkg::result_t out_q, out_d;

  logic            out_free;
  logic            load;
  logic [AW:0]     size;
  logic [AW:0]     cur_size;
  logic            fits;
  logic [ps2mq_pkg::UsedBits-1:0] used_sat;
  logic            ram_en, ram_we;
  logic [AW-1:0]   ram_addr;
  logic [7:0]      ram_rdata;

  assign out_free = !out_valid_q || res_ready_i;
  assign size     = cmd_i.wide ? (AW + 1)'(4) : (AW + 1)'(3);
  assign cur_size = pkt_q.wide ? (AW + 1)'(4) : (AW + 1)'(3);
  assign fits     = ({1'b0, count_q} + size) < DepthC;

  if (AW > ps2mq_pkg::UsedBits) begin : g_sat
    assign used_sat = (count_q > AW'(63)) ? 6'd63 : count_q[ps2mq_pkg::UsedBits-1:0];
  end else begin : g_nosat
    assign used_sat = ps2mq_pkg::UsedBits'(count_q);
  end

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    return (p == LastSlot) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    state_d   = state_q;
    wr_ptr_d  = wr_ptr_q;
    rd_ptr_d  = rd_ptr_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pkt_d     = pkt_q;
    cmd_pop_o = 1'b0;
    load      = 1'b0;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = rd_ptr_q;
    out_d     = out_q;
    out_d.read_valid     = 1'b0;
    out_d.read_byte      = 8'd0;
    out_d.packet_queued  = 1'b0;
    out_d.packet_dropped = 1'b0;
    out_d.has_data       = (count_q != '0);
    out_d.bytes_used     = used_sat;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            ps2mq_pkg::CMD_READ: begin
              if (count_q != '0) begin
                ram_en    = 1'b1;
                cmd_pop_o = 1'b1;
                rd_ptr_d  = next_slot(rd_ptr_q);
                count_d   = count_q - AW'(1);
                state_d   = ST_RWAIT;
              end else if (out_free) begin
                cmd_pop_o = 1'b1;
                load      = 1'b1;
              end
            end
            ps2mq_pkg::CMD_PACKET: begin
              if (fits) begin
                cmd_pop_o = 1'b1;
                pkt_d     = cmd_i;
                idx_d     = 2'd0;
                state_d   = ST_WR;
              end else if (out_free) begin
                cmd_pop_o            = 1'b1;
                load                 = 1'b1;
                out_d.packet_dropped = 1'b1;
              end
            end
            default: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                load      = 1'b1;
              end
            end
          endcase
        end
      end
      ST_WR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = wr_ptr_q;
        wr_ptr_d = next_slot(wr_ptr_q);
        idx_d    = idx_q + 2'd1;
        if (idx_q == (pkt_q.wide ? 2'd3 : 2'd2)) begin
          count_d = AW'({1'b0, count_q} + cur_size);
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          load                = 1'b1;
          out_d.packet_queued = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        if (out_free) begin
          load             = 1'b1;
          out_d.read_valid = 1'b1;
          out_d.read_byte  = ram_rdata;
          state_d          = ST_IDLE;
        end
      end
    endcase

    out_valid_d = (out_valid_q && !res_ready_i) || load;
  end

  ps2mq_ram #(
    .Width(8),
    .Depth(QueueDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(pkt_q.bytes[idx_q]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    pkt_q <= pkt_d;
    if (load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

`ifndef SYNTHESIS
  // One slot always stays spare.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LastSlot)
    else $error("queue fill exceeds depth minus one");

  // The write pointer runs ahead of the fill count while a packet is written,
  // so the two only have to agree on emptiness outside of that.
  a_empty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_WR) |-> ((count_q == '0) == (wr_ptr_q == rd_ptr_q)))
    else $error("fill count and pointers disagree");

  // A packet is only written when all of its bytes fit.
  a_pkt_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR && idx_q == 2'd0) |-> (({1'b0, count_q} + cur_size) < DepthC))
    else $error("packet write started without room");

  // A read result carries the byte fetched in the idle state; the read data holds until it is loaded.
  a_read_after_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RWAIT) |-> ($past(state_q) == ST_IDLE || $past(state_q) == ST_RWAIT))
    else $error("read wait entered without a fetch");
`endif

endmodule

`default_nettype wire
